FILE: rtl/topt_pkg.sv
// Package for the 2-opt tour improver: item kinds, sequencer states and
// fixed widths used by the top level.
// No dependencies.
package topt_pkg;

  // Fixed field widths.
  localparam int CITY_W    = 6;
  localparam int CNT_W     = 7;
  localparam int DADDR_W   = 2 * CITY_W;
  localparam int STORE_SIDE = 64;
  localparam int SWAP_W    = 32;

  // A run stops after this many reversals.
  localparam logic [SWAP_W-1:0] SWAP_LIMIT = 32'd65536;
  localparam logic [SWAP_W-1:0] SWAP_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_DIST = 2'd0,
    KIND_TOUR = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_EV,
    S_OUT_INV,
    S_PASS,
    S_I_RD0,
    S_I_RD1,
    S_I_RD2,
    S_I_RD3,
    S_J_RD0,
    S_J_RD1,
    S_J_RD2,
    S_J_D1,
    S_J_D2,
    S_J_EV,
    S_J_CMP,
    S_P_END,
    S_REV_A,
    S_REV_B,
    S_REV_W1,
    S_REV_W2,
    S_EM_RD,
    S_EM_WAIT
  } state_t;

endpackage

FILE: rtl/two_opt_tour_improver_top.sv
// Top level of the best-improvement 2-opt tour improver: sequencer around a
// distance RAM and a tour RAM. Depends on topt_pkg and topt_ram.
//
//  Channel | Direction | Signals
//  in      | input     | in_valid/in_ready, kind, row/col, distance, tour entry
//  out     | output    | out_valid/out_ready, position, city, swap_count, status, last
//  cfg     | input     | cfg_we, cfg_data (city_count)
//
// Load items are accepted only while idle and written to the RAMs directly.
// A run first checks every tour entry, then makes passes that read two tour
// entries and three distances per pair through the single read port of each
// RAM; a reversal swaps element pairs from both ends. Reset is synchronous
// and clears control state only; RAM contents are undefined until loaded.
// A stalled output holds the sequencer in emission.
module two_opt_tour_improver_top #(
  parameter int MAX_CITIES = 64,
  parameter int DIST_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_row_city,
  input  logic [5:0]  in_col_city,
  input  logic [31:0] in_distance,
  input  logic [5:0]  in_tour_position,
  input  logic [5:0]  in_tour_city,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_position,
  output logic [5:0]  out_city,
  output logic [31:0] out_swap_count,
  output logic        out_status,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  localparam int CW = topt_pkg::CITY_W;
  localparam int NW = topt_pkg::CNT_W;
  localparam int SW = topt_pkg::SWAP_W;
  localparam int GW = DIST_BITS + 1;

  topt_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]        city_count_r;
  logic [NW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]        cl_r, cl_nxt, cr_r, cr_nxt, ol_r, ol_nxt, orr_r, orr_nxt;
  logic [CW-1:0]        a_r, a_nxt, b_r, b_nxt, ta_r, ta_nxt;
  logic [CW-1:0]        best_i_r, best_i_nxt, best_j_r, best_j_nxt;
  logic [DIST_BITS-1:0] dclcr_r, dclcr_nxt, dclol_r, dclol_nxt;
  logic [GW-1:0]        old_sum_r, old_sum_nxt, new_sum_r, new_sum_nxt;
  logic [GW-1:0]        best_gain_r, best_gain_nxt, gain;
  logic [SW-1:0]        swaps_r, swaps_nxt;
  logic                 invalid_r, invalid_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        out_pos_r, out_pos_nxt, out_city_r, out_city_nxt;
  logic [SW-1:0]        out_swaps_r, out_swaps_nxt;
  logic                 out_status_r, out_status_nxt, out_last_r, out_last_nxt;

  // RAM ports.
  logic                              dist_we, dist_re;
  logic [topt_pkg::DADDR_W-1:0]      dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0]              dist_rdata;
  logic                              tour_we, tour_re;
  logic [CW-1:0]                     tour_waddr, tour_raddr, tour_wdata, tour_rdata;

  logic       in_xfer, out_free;
  logic [NW-1:0] n_cfg;
  logic [CW-1:0] j_wrap;

  topt_ram #(.WIDTH(DIST_BITS), .DEPTH(topt_pkg::STORE_SIDE * topt_pkg::STORE_SIDE))
  u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (DIST_BITS'(in_distance)),
    .re    (dist_re),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  topt_ram #(.WIDTH(CW), .DEPTH(topt_pkg::STORE_SIDE)) u_tour_ram (
    .clk   (clk),
    .we    (tour_we),
    .waddr (tour_waddr),
    .wdata (tour_wdata),
    .re    (tour_re),
    .raddr (tour_raddr),
    .rdata (tour_rdata)
  );

  assign in_ready = (state_r == topt_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Clamp the configured city count into the supported range.
  always_comb begin
    if (city_count_r < NW'(2)) begin
      n_cfg = NW'(2);
    end else if (city_count_r > NW'(MAX_CITIES)) begin
      n_cfg = NW'(MAX_CITIES);
    end else begin
      n_cfg = city_count_r;
    end
  end

  // Successor position of j, wrapping to position zero.
  assign j_wrap = ({1'b0, j_r} + NW'(1) == n_r) ? '0 : j_r + CW'(1);
  assign gain   = old_sum_r - new_sum_r;

  // Sequencer: next state, RAM accesses and datapath updates.
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cl_nxt         = cl_r;
    cr_nxt         = cr_r;
    ol_nxt         = ol_r;
    orr_nxt        = orr_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    ta_nxt         = ta_r;
    best_i_nxt     = best_i_r;
    best_j_nxt     = best_j_r;
    dclcr_nxt      = dclcr_r;
    dclol_nxt      = dclol_r;
    old_sum_nxt    = old_sum_r;
    new_sum_nxt    = new_sum_r;
    best_gain_nxt  = best_gain_r;
    swaps_nxt      = swaps_r;
    invalid_nxt    = invalid_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pos_nxt    = out_pos_r;
    out_city_nxt   = out_city_r;
    out_swaps_nxt  = out_swaps_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    dist_we        = 1'b0;
    dist_waddr     = {in_row_city, in_col_city};
    dist_re        = 1'b0;
    dist_raddr     = '0;
    tour_we        = 1'b0;
    tour_waddr     = in_tour_position;
    tour_wdata     = in_tour_city;
    tour_re        = 1'b0;
    tour_raddr     = '0;

    case (state_r)
      topt_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (topt_pkg::kind_t'(in_kind))
            topt_pkg::KIND_DIST: dist_we = 1'b1;
            topt_pkg::KIND_TOUR: tour_we = 1'b1;
            topt_pkg::KIND_RUN: begin
              n_nxt       = n_cfg;
              k_nxt       = '0;
              swaps_nxt   = '0;
              invalid_nxt = 1'b0;
              state_nxt   = topt_pkg::S_CHK_RD;
            end
            default: ;
          endcase
        end
      end
      // Check every tour entry against the city count.
      topt_pkg::S_CHK_RD: begin
        tour_re    = 1'b1;
        tour_raddr = k_r;
        state_nxt  = topt_pkg::S_CHK_EV;
      end
      topt_pkg::S_CHK_EV: begin
        if ({1'b0, tour_rdata} >= n_r) begin
          invalid_nxt = 1'b1;
        end
        if ({1'b0, k_r} == n_r - NW'(1)) begin
          if (invalid_r || ({1'b0, tour_rdata} >= n_r)) begin
            state_nxt = topt_pkg::S_OUT_INV;
          end else begin
            state_nxt = topt_pkg::S_PASS;
          end
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = topt_pkg::S_CHK_RD;
        end
      end
      topt_pkg::S_OUT_INV: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = '0;
          out_city_nxt   = '0;
          out_swaps_nxt  = '0;
          out_status_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = topt_pkg::S_IDLE;
        end
      end
      // Start a pass unless the swap limit is reached.
      topt_pkg::S_PASS: begin
        best_gain_nxt = '0;
        best_i_nxt    = '0;
        best_j_nxt    = '0;
        i_nxt         = '0;
        k_nxt         = '0;
        if (swaps_r >= topt_pkg::SWAP_LIMIT) begin
          state_nxt = topt_pkg::S_EM_RD;
        end else begin
          state_nxt = topt_pkg::S_I_RD0;
        end
      end
      topt_pkg::S_I_RD0: begin
        tour_re    = 1'b1;
        tour_raddr = i_r;
        state_nxt  = topt_pkg::S_I_RD1;
      end
      topt_pkg::S_I_RD1: begin
        cl_nxt     = tour_rdata;
        tour_re    = 1'b1;
        tour_raddr = i_r + CW'(1);
        state_nxt  = topt_pkg::S_I_RD2;
      end
      topt_pkg::S_I_RD2: begin
        cr_nxt     = tour_rdata;
        dist_re    = 1'b1;
        dist_raddr = {cl_r, tour_rdata};
        state_nxt  = topt_pkg::S_I_RD3;
      end
      topt_pkg::S_I_RD3: begin
        dclcr_nxt = dist_rdata;
        j_nxt     = i_r + CW'(1);
        state_nxt = topt_pkg::S_J_RD0;
      end
      // Inner scan over j for the current i.
      topt_pkg::S_J_RD0: begin
        tour_re    = 1'b1;
        tour_raddr = j_r;
        state_nxt  = topt_pkg::S_J_RD1;
      end
      topt_pkg::S_J_RD1: begin
        ol_nxt     = tour_rdata;
        tour_re    = 1'b1;
        tour_raddr = j_wrap;
        state_nxt  = topt_pkg::S_J_RD2;
      end
      topt_pkg::S_J_RD2: begin
        orr_nxt    = tour_rdata;
        dist_re    = 1'b1;
        dist_raddr = {ol_r, tour_rdata};
        state_nxt  = topt_pkg::S_J_D1;
      end
      topt_pkg::S_J_D1: begin
        old_sum_nxt = {1'b0, dclcr_r} + {1'b0, dist_rdata};
        dist_re     = 1'b1;
        dist_raddr  = {cl_r, ol_r};
        state_nxt   = topt_pkg::S_J_D2;
      end
      topt_pkg::S_J_D2: begin
        dclol_nxt  = dist_rdata;
        dist_re    = 1'b1;
        dist_raddr = {cr_r, orr_r};
        state_nxt  = topt_pkg::S_J_EV;
      end
      topt_pkg::S_J_EV: begin
        new_sum_nxt = {1'b0, dclol_r} + {1'b0, dist_rdata};
        state_nxt   = topt_pkg::S_J_CMP;
      end
      topt_pkg::S_J_CMP: begin
        // Only a strictly larger gain replaces the best pair.
        if ((old_sum_r > new_sum_r) && (gain > best_gain_r)) begin
          best_gain_nxt = gain;
          best_i_nxt    = i_r;
          best_j_nxt    = j_r;
        end
        if ({1'b0, j_r} == n_r - NW'(1)) begin
          if ({1'b0, i_r} == n_r - NW'(2)) begin
            state_nxt = topt_pkg::S_P_END;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = topt_pkg::S_I_RD0;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = topt_pkg::S_J_RD0;
        end
      end
      topt_pkg::S_P_END: begin
        if (best_gain_r == '0) begin
          k_nxt     = '0;
          state_nxt = topt_pkg::S_EM_RD;
        end else begin
          a_nxt     = best_i_r + CW'(1);
          b_nxt     = best_j_r;
          state_nxt = topt_pkg::S_REV_A;
        end
      end
      // Reverse positions a..b by swapping from both ends.
      topt_pkg::S_REV_A: begin
        if (a_r < b_r) begin
          tour_re    = 1'b1;
          tour_raddr = a_r;
          state_nxt  = topt_pkg::S_REV_B;
        end else begin
          if (swaps_r != topt_pkg::SWAP_MAX) begin
            swaps_nxt = swaps_r + SW'(1);
          end
          state_nxt = topt_pkg::S_PASS;
        end
      end
      topt_pkg::S_REV_B: begin
        ta_nxt     = tour_rdata;
        tour_re    = 1'b1;
        tour_raddr = b_r;
        state_nxt  = topt_pkg::S_REV_W1;
      end
      topt_pkg::S_REV_W1: begin
        tour_we    = 1'b1;
        tour_waddr = a_r;
        tour_wdata = tour_rdata;
        state_nxt  = topt_pkg::S_REV_W2;
      end
      topt_pkg::S_REV_W2: begin
        tour_we    = 1'b1;
        tour_waddr = b_r;
        tour_wdata = ta_r;
        a_nxt      = a_r + CW'(1);
        b_nxt      = b_r - CW'(1);
        state_nxt  = topt_pkg::S_REV_A;
      end
      // Emit the tour one city per transfer.
      topt_pkg::S_EM_RD: begin
        tour_re    = 1'b1;
        tour_raddr = k_r;
        state_nxt  = topt_pkg::S_EM_WAIT;
      end
      topt_pkg::S_EM_WAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = k_r;
          out_city_nxt   = tour_rdata;
          out_swaps_nxt  = swaps_r;
          out_status_nxt = 1'b0;
          out_last_nxt   = ({1'b0, k_r} == n_r - NW'(1));
          if ({1'b0, k_r} == n_r - NW'(1)) begin
            state_nxt = topt_pkg::S_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = topt_pkg::S_EM_RD;
          end
        end
      end
      default: state_nxt = topt_pkg::S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= topt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      city_count_r <= NW'(64);
      swaps_r      <= '0;
      invalid_r    <= 1'b0;
      best_gain_r  <= '0;
      best_i_r     <= '0;
      best_j_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      swaps_r     <= swaps_nxt;
      invalid_r   <= invalid_nxt;
      best_gain_r <= best_gain_nxt;
      best_i_r    <= best_i_nxt;
      best_j_r    <= best_j_nxt;
      if (cfg_we) begin
        city_count_r <= cfg_data;
      end
    end
  end

  // Datapath and output payload registers.
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    cl_r         <= cl_nxt;
    cr_r         <= cr_nxt;
    ol_r         <= ol_nxt;
    orr_r        <= orr_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    ta_r         <= ta_nxt;
    dclcr_r      <= dclcr_nxt;
    dclol_r      <= dclol_nxt;
    old_sum_r    <= old_sum_nxt;
    new_sum_r    <= new_sum_nxt;
    out_pos_r    <= out_pos_nxt;
    out_city_r   <= out_city_nxt;
    out_swaps_r  <= out_swaps_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_pos_r;
  assign out_city       = out_city_r;
  assign out_swap_count = out_swaps_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

FILE: rtl/topt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module topt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/topt_chk.sv
// Port checker for the 2-opt tour improver, bound to the top level.
// Depends on two_opt_tour_improver_top ports only.
module topt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_position,
  input logic [5:0]  out_city,
  input logic [31:0] out_swap_count,
  input logic        out_status,
  input logic        out_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An invalid-tour status is a single, final result.
  a_inv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last)
    else $error("invalid status not on last result");

  // The invalid-tour result carries zeros.
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_position == 6'd0) && (out_city == 6'd0)
      && (out_swap_count == 32'd0))
    else $error("invalid result payload not zero");

  // A run never reports more reversals than the swap limit.
  a_swap_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_swap_count <= 32'd65536)
    else $error("swap count above limit");

endmodule

bind two_opt_tour_improver_top topt_chk u_topt_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_position   (out_position),
  .out_city       (out_city),
  .out_swap_count (out_swap_count),
  .out_status     (out_status),
  .out_last       (out_last)
);
